### rtl/thd_pkg.sv
package thd_pkg;

    localparam logic [7:0] CHAR_BASE_RESET = 8'd97;
    localparam int unsigned WIN_BITS = 7;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef logic [WIN_BITS-1:0] t_window;
    typedef logic [2:0]          t_count;

    typedef struct packed {
        logic [7:0] letter;
        logic       done;
    } t_result;

    function automatic logic [7:0] code_word(input t_window idx);
        logic [7:0] w;
        w = 8'h00;
        case (idx[6:4])
            3'd0: w = 8'hb3;
            3'd1: w = 8'hc3;
            3'd2: begin
                if (idx[3] == 1'b0) begin
                    w = 8'h74;
                end else if (idx[2] == 1'b0) begin
                    w = 8'h65;
                end else begin
                    w = 8'h55;
                end
            end
            3'd3: w = (idx[3] == 1'b0) ? 8'h84 : 8'h94;
            3'd4: w = 8'hd3;
            3'd5: w = 8'he3;
            3'd6: begin
                if (idx[3] == 1'b0) begin
                    w = 8'ha4;
                end else begin
                    case (idx[2:0])
                        3'd0, 3'd1: w = 8'h46;
                        3'd2, 3'd3: w = 8'h36;
                        3'd4:       w = 8'h07;
                        3'd5:       w = 8'h17;
                        default:    w = 8'h26;
                    endcase
                end
            end
            default: w = 8'hf3;
        endcase
        return w;
    endfunction

endpackage

### rtl/table_huffman_bit_decoder.sv
// Prefix-code decoder taking one coded bit per beat, most significant first.
// A new bit is accepted every cycle while the four-entry result queue has room
// for two letters; each bit is decoded in the cycle it is accepted and its
// letters (none, one, or two on the final bit) enter the queue at the next
// clock edge. The output drains one letter per cycle while i_out_ready is
// high. The final bit of a message, flagged by i_end_of_stream, flushes the
// pending bits with zero padding and marks the last letter with o_message_done;
// the window then restarts empty. The character base is written through
// i_cfg_we/i_cfg_data while the block is idle, a rule for the user that the
// block itself does not enforce; it resets to 97.
module table_huffman_bit_decoder
    import thd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_code_bit,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_letter,
    output logic       o_message_done
);

    logic [7:0] r_char_base;
    t_window    r_window, n_window;
    t_count     r_count, n_count;

    t_result    r_queue [QUEUE_DEPTH];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [2:0] r_fill, n_fill;

    logic       in_acc, out_acc;
    t_count     cnt_base, cnt_one, cnt_a, pad_shift;
    t_window    win_one, win_a, win_pad;
    logic       full;
    logic [7:0] word0, word_pad;
    logic [3:0] len0;
    logic       need_pad;
    t_result    res_full, res_pad, push0, push1;
    logic [1:0] push_n;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;
    assign o_in_ready = (r_fill <= 3'd2);
    assign o_out_valid = (r_fill != 3'd0);
    assign o_letter       = r_queue[r_rd_ptr].letter;
    assign o_message_done = r_queue[r_rd_ptr].done;

    always_comb begin
        cnt_base = (r_count > 3'd6) ? 3'd6 : r_count;
        win_one  = {r_window[WIN_BITS-2:0], i_code_bit};
        cnt_one  = cnt_base + 3'd1;
        full     = (cnt_one == 3'(WIN_BITS));
        word0    = code_word(win_one);
        len0     = (word0[3:0] > 4'(WIN_BITS)) ? 4'(WIN_BITS) : word0[3:0];
        if (full) begin
            cnt_a = 3'(4'(WIN_BITS) - len0);
            win_a = win_one & ((t_window'(1) << cnt_a) - t_window'(1));
        end else begin
            cnt_a = cnt_one;
            win_a = win_one;
        end
        res_full.letter = 8'(word0[7:4]) + r_char_base;
        res_full.done   = i_end_of_stream && (cnt_a == 3'd0);

        need_pad  = i_end_of_stream && (!full || cnt_a != 3'd0);
        pad_shift = 3'(WIN_BITS) - cnt_a;
        win_pad   = win_a << pad_shift;
        word_pad  = code_word(win_pad);
        res_pad.letter = 8'(word_pad[7:4]) + r_char_base;
        res_pad.done   = 1'b1;

        push0  = full ? res_full : res_pad;
        push1  = res_pad;
        push_n = 2'(full) + 2'(need_pad);
        if (!in_acc) begin
            push_n = 2'd0;
        end

        n_window = i_end_of_stream ? '0 : win_a;
        n_count  = i_end_of_stream ? '0 : cnt_a;
        n_fill   = r_fill + 3'(push_n) - 3'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_base <= CHAR_BASE_RESET;
            r_window    <= '0;
            r_count     <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_char_base <= i_cfg_data;
            end
            if (in_acc) begin
                r_window <= n_window;
                r_count  <= n_count;
            end
            r_wr_ptr <= r_wr_ptr + push_n;
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= push0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= push1;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd6)
        else $error("pending bit count out of range");

    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_stream) |=> (r_count == 3'd0 && r_window == '0))
        else $error("window not cleared after final bit");

    a_final_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_stream) |-> (push_n != 2'd0))
        else $error("final bit produced no letter");

endmodule
